// ===== design/mme_pkg.sv =====
// Shared types and constants for the matrix multiply engine.
// Used by the top level, the multiply-accumulate unit and the port checker.
// No dependencies.
package mme_pkg;

    // Fixed field widths of the stream items
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 6;
    localparam int ELEM_IN_W = 16;
    localparam int PROD_W    = 38;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 7'd64;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIM      = 64;
    localparam int DEF_ELEMENT_BITS = 16;

    // Operation selected by an input item
    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_A = 2'd0,
        FUNC_WR_B = 2'd1,
        FUNC_RD   = 2'd2,
        FUNC_NOP  = 2'd3
    } t_func;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS  = 2'd0,
        CFG_COLS  = 2'd1,
        CFG_INNER = 2'd2
    } t_cfg_idx;

    // Commands from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic rd_en;
        logic clear;
    } t_mac_ctrl;

endpackage

// ===== design/mme_mac.sv =====
// Operand stores and the shared multiply-accumulate unit.
// Depends on mme_pkg for the control struct and the result width.
module mme_mac
    import mme_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS,
    parameter int ADDR_W       = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_ctrl               i_ctrl,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic [ELEMENT_BITS-1:0] i_wr_data,
    input  logic [ADDR_W-1:0]       i_rd_addr_a,
    input  logic [ADDR_W-1:0]       i_rd_addr_b,
    output logic                    o_busy,
    output logic [PROD_W-1:0]       o_acc
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int MULT_W = 2 * ELEMENT_BITS;

    logic [ELEMENT_BITS-1:0] mem_a [CELLS];
    logic [ELEMENT_BITS-1:0] mem_b [CELLS];

    logic [ELEMENT_BITS-1:0] r_a_data;
    logic [ELEMENT_BITS-1:0] r_b_data;
    logic                    r_rd_vld;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_prod_vld;
    logic [PROD_W-1:0]       r_acc;

    logic signed [MULT_W-1:0]        mult;
    logic signed [MULT_W+PROD_W-1:0] mult_ext;

    // Operand stores: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_a) begin
            mem_a[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.wr_b) begin
            mem_b[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_a_data <= mem_a[i_rd_addr_a];
            r_b_data <= mem_b[i_rd_addr_b];
        end
    end

    // Signed product, then sign-extended or wrapped to the result width.
    always_comb begin
        mult     = $signed(r_a_data) * $signed(r_b_data);
        mult_ext = mult;
    end

    // Product register and accumulator; the sum wraps at the result width.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prod <= mult_ext[PROD_W-1:0];
        end
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_ctrl.rd_en;
            r_prod_vld <= r_rd_vld;
        end
    end

    assign o_busy = r_rd_vld || r_prod_vld;
    assign o_acc  = r_acc;

endmodule

// ===== design/matrix_multiply_engine_top.sv =====
// Top level of the matrix multiply engine: stream ports, configuration
// registers and the read sequencer. Depends on mme_pkg and mme_mac.
//
// Writes of either operand matrix can follow one another back to back. A
// product read walks the inner dimension through one shared multiplier and
// accumulator, issuing one store read per cycle (an out-of-range read or an
// inner size of zero skips the walk); the input is not ready from its accept
// until its result is loaded into the output register. An inner size above
// MAX_DIM counts as MAX_DIM. The read also waits as long as an earlier result
// still sits unaccepted in the output register. The result sits in an output
// register, so writes keep being accepted while it waits.
module matrix_multiply_engine_top
    import mme_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // row_index, col_index, element_value
    input  logic [FUNC_W-1:0]    s_axis_tuser,  // func
    // Result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // out_row, out_col, product_value
    output logic                 m_axis_tuser   // in_range
);

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int K_W    = $clog2(MAX_DIM);
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int M_PAD_W = M_TDATA_W - 2 * IDX_W - PROD_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_rows;
    logic [CFG_W-1:0]     r_cols;
    logic [CFG_W-1:0]     r_inner;
    logic [IDX_W-1:0]     r_row;
    logic [IDX_W-1:0]     r_col;
    logic [K_W-1:0]       r_k;
    logic                 r_in_range;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic                 r_m_user;

    t_func                   in_func;
    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic [ELEM_IN_W-1:0]    in_elem;
    logic [ELEM_IN_W+ELEMENT_BITS-1:0] elem_ext;
    logic                    accept;
    logic                    rd_start;
    logic                    wr_ok;
    logic                    rd_ok;
    logic [CNT_W-1:0]        dim_rows;
    logic [CNT_W-1:0]        dim_cols;
    logic [CNT_W-1:0]        dim_inner;
    logic                    last_k;
    logic                    out_free;
    logic                    out_load;
    t_mac_ctrl               mac_ctrl;
    logic [ADDR_W-1:0]       wr_addr;
    logic [ELEMENT_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]       rd_addr_a;
    logic [ADDR_W-1:0]       rd_addr_b;
    logic                    mac_busy;
    logic [PROD_W-1:0]       mac_acc;

    // Unpack the input item.
    assign in_func = t_func'(s_axis_tuser);
    assign in_row  = s_axis_tdata[IDX_W-1:0];
    assign in_col  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_elem = s_axis_tdata[2*IDX_W+ELEM_IN_W-1:2*IDX_W];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rd_start      = accept && (in_func == FUNC_RD);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= CFG_DIM_RESET;
            r_cols  <= CFG_DIM_RESET;
            r_inner <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:  r_rows  <= i_cfg_data;
                CFG_COLS:  r_cols  <= i_cfg_data;
                CFG_INNER: r_inner <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sizes saturate at the store dimension.
    always_comb begin
        dim_rows  = (32'(r_rows) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_rows);
        dim_cols  = (32'(r_cols) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_cols);
        dim_inner = (32'(r_inner) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(r_inner);
    end

    // Element writes land at row * MAX_DIM + col when inside the store.
    assign elem_ext = {{ELEMENT_BITS{1'b0}}, in_elem};
    assign wr_data  = elem_ext[ELEMENT_BITS-1:0];
    assign wr_ok    = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign wr_addr  = ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col);
    assign rd_ok    = (32'(in_row) < 32'(dim_rows)) && (32'(in_col) < 32'(dim_cols));

    // Read addresses step along row r_row of A and column r_col of B.
    assign rd_addr_a = ADDR_W'(r_row) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k);
    assign rd_addr_b = ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_col);
    assign last_k    = (CNT_W'(r_k) == CNT_W'(dim_inner - CNT_W'(1)));
    assign out_free  = !r_m_valid || m_axis_tready;
    assign out_load  = (r_state == S_DONE) && out_free;

    always_comb begin
        mac_ctrl.wr_a  = accept && (in_func == FUNC_WR_A) && wr_ok;
        mac_ctrl.wr_b  = accept && (in_func == FUNC_WR_B) && wr_ok;
        mac_ctrl.rd_en = (r_state == S_RUN);
        mac_ctrl.clear = rd_start;
    end

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            if (r_m_valid && m_axis_tready && !out_load) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (rd_start) begin
                        r_row      <= in_row;
                        r_col      <= in_col;
                        r_k        <= '0;
                        r_in_range <= rd_ok;
                        if (rd_ok && (dim_inner != '0)) begin
                            r_state <= S_RUN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RUN: begin
                    r_k <= r_k + K_W'(1);
                    if (last_k) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!mac_busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {{M_PAD_W{1'b0}}, mac_acc, r_col, r_row};
                        r_m_user  <= r_in_range;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    mme_mac #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS),
        .ADDR_W       (ADDR_W)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (mac_ctrl),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_busy      (mac_busy),
        .o_acc       (mac_acc)
    );

endmodule

// ===== design/mme_checker.sv =====
// Port-level checks for the matrix multiply engine, bound to the top level.
// Depends on mme_pkg for field widths and the operation codes.
module mme_checker
    import mme_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [FUNC_W-1:0]    s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tuser
);

    // A result that is not taken stays as it is.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // A product read occupies the engine for at least the following cycle.
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_RD) |=> !s_axis_tready)
        else $error("input ready right after a product read");

    // A write never produces a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
        (s_axis_tuser == FUNC_WR_A || s_axis_tuser == FUNC_WR_B) |=> !m_axis_tvalid)
        else $error("result item appeared after a write");

    // An out-of-range result carries a zero product.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[2*IDX_W+PROD_W-1:2*IDX_W] == '0)
        else $error("out-of-range result with nonzero product");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (.*);
